[hdl/dlas_pkg.sv]
// Shared types, constants and helpers for the dual-half LCD address sequencer.
// Depends on nothing; every other file but dlas_if imports it.
package dlas_pkg;

  // Panel geometry. All four are powers of two, so divisions become shifts and masks.
  localparam int unsigned PANEL_WIDTH   = 128;
  localparam int unsigned PANEL_HEIGHT  = 64;
  localparam int unsigned HALF_WIDTH    = 64;
  localparam int unsigned ROWS_PER_PAGE = 8;

  localparam int unsigned COL_W    = (PANEL_WIDTH > 2) ? $clog2(PANEL_WIDTH) : 1;
  localparam int unsigned ROW_W    = $clog2(PANEL_HEIGHT);
  localparam int unsigned HALF_LOG = $clog2(HALF_WIDTH);
  localparam int unsigned PAGE_LOG = $clog2(ROWS_PER_PAGE);

  // Most results one request can cause, and the counter widths that follow.
  localparam int unsigned MAX_RES = 5;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  // Panel instruction bytes.
  localparam logic [7:0] CMD_DISPLAY_ON = 8'b0011_1110 | 8'h01;
  localparam logic [7:0] CMD_SET_COLUMN = 8'b0100_0000;
  localparam logic [7:0] CMD_SET_PAGE   = 8'b1011_1000;
  localparam logic [7:0] CMD_START_LINE = 8'b1100_0000;

  typedef enum logic [2:0] {
    FUNC_INIT     = 3'd0,
    FUNC_SET_ADDR = 3'd1,
    FUNC_WRITE    = 3'd2,
    FUNC_READ     = 3'd3,
    FUNC_REPLY    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_INSTR = 2'd0,
    KIND_WDATA = 2'd1,
    KIND_RDATA = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    kind_e      kind;
    logic       half;
    logic [7:0] bus_byte;
    logic       error;
  } res_t;

  // All results of one request, oldest in slot 0.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } burst_t;

  typedef struct packed {
    col_t   col;
    row_t   row;
    phase_e phase;
  } pos_t;

  function automatic logic half_of(col_t col);
    col_t sh;
    sh = col >> HALF_LOG;
    return sh[0];
  endfunction

  function automatic res_t res_make(kind_e kind, logic half, logic [7:0] b, logic err);
    res_t r;
    r.kind     = kind;
    r.half     = half;
    r.bus_byte = b;
    r.error    = err;
    return r;
  endfunction

  function automatic res_t page_cmd(col_t col, row_t row);
    row_t pg;
    pg = row >> PAGE_LOG;
    return res_make(KIND_INSTR, half_of(col), CMD_SET_PAGE | 8'(pg), 1'b0);
  endfunction

  function automatic res_t column_cmd(col_t col);
    logic [7:0] c;
    c = 8'(col) & 8'(HALF_WIDTH - 1);
    return res_make(KIND_INSTR, half_of(col), CMD_SET_COLUMN | c, 1'b0);
  endfunction

endpackage

[hdl/dlas_if.sv]
// Valid/ready channel interfaces for request and result beats.
// Depends on nothing.
interface dlas_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x_col;
  logic [7:0] y_row;
  logic [7:0] byte_value;

  modport source (output valid, func, x_col, y_row, byte_value, input ready);
  modport sink   (input valid, func, x_col, y_row, byte_value, output ready);
endinterface

interface dlas_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       half;
  logic [7:0] bus_byte;
  logic       error;
  logic       last;

  modport source (output valid, kind, half, bus_byte, error, last, input ready);
  modport sink   (input valid, kind, half, bus_byte, error, last, output ready);
endinterface

[hdl/dlas_decode.sv]
// Request decoder: turns one request plus the current position into its result list
// and the next position. Purely combinational. Depends on dlas_pkg.
module dlas_decode import dlas_pkg::*; (
  input  logic [2:0] func_i,
  input  logic [7:0] x_col_i,
  input  logic [7:0] y_row_i,
  input  logic [7:0] byte_value_i,
  input  pos_t       pos_i,
  output burst_t     burst_o,
  output pos_t       pos_o
);

  logic [COL_W:0] col_inc;
  logic           wrap;
  logic           adv_addr;
  col_t           adv_col;
  row_t           adv_row;
  logic           in_range;
  logic           pending;
  col_t           new_col;
  row_t           new_row;

  // Column advance after a data beat; wrap takes precedence over the half boundary.
  assign col_inc  = {1'b0, pos_i.col} + (COL_W + 1)'(1);
  assign wrap     = col_inc >= (COL_W + 1)'(PANEL_WIDTH);
  assign adv_col  = wrap ? '0 : col_inc[COL_W-1:0];
  assign adv_row  = wrap ? pos_i.row + ROW_W'(ROWS_PER_PAGE) : pos_i.row;
  assign adv_addr = wrap || (col_inc == (COL_W + 1)'(HALF_WIDTH));

  assign in_range = ({1'b0, x_col_i} < 9'(PANEL_WIDTH)) &&
                    ({1'b0, y_row_i} < 9'(PANEL_HEIGHT));
  assign pending  = pos_i.phase != PH_IDLE;
  assign new_col  = x_col_i[COL_W-1:0];
  assign new_row  = y_row_i[ROW_W-1:0];

  always_comb begin
    burst_o = '0;
    pos_o   = pos_i;
    burst_o.res[0] = res_make(KIND_DONE, 1'b0, 8'h00, 1'b1);
    burst_o.cnt    = CNT_W'(1);
    unique case (func_e'(func_i))
      FUNC_INIT: begin
        if (!pending) begin
          burst_o.res[0] = res_make(KIND_INSTR, 1'b0, CMD_DISPLAY_ON, 1'b0);
          burst_o.res[1] = res_make(KIND_INSTR, 1'b1, CMD_DISPLAY_ON, 1'b0);
          burst_o.res[2] = res_make(KIND_INSTR, 1'b0, CMD_START_LINE, 1'b0);
          burst_o.res[3] = res_make(KIND_INSTR, 1'b1, CMD_START_LINE, 1'b0);
          burst_o.res[4] = res_make(KIND_DONE, 1'b0, 8'h00, 1'b0);
          burst_o.cnt    = CNT_W'(5);
          pos_o.col      = '0;
          pos_o.row      = '0;
        end
      end
      FUNC_SET_ADDR: begin
        if (!pending && in_range) begin
          burst_o.res[0] = page_cmd(new_col, new_row);
          burst_o.res[1] = column_cmd(new_col);
          burst_o.res[2] = res_make(KIND_DONE, 1'b0, 8'h00, 1'b0);
          burst_o.cnt    = CNT_W'(3);
          pos_o.col      = new_col;
          pos_o.row      = new_row;
        end
      end
      FUNC_WRITE: begin
        if (!pending) begin
          burst_o.res[0] = res_make(KIND_WDATA, half_of(pos_i.col), byte_value_i, 1'b0);
          if (adv_addr) begin
            burst_o.res[1] = page_cmd(adv_col, adv_row);
            burst_o.res[2] = column_cmd(adv_col);
            burst_o.res[3] = res_make(KIND_DONE, 1'b0, 8'h00, 1'b0);
            burst_o.cnt    = CNT_W'(4);
          end else begin
            burst_o.res[1] = res_make(KIND_DONE, 1'b0, 8'h00, 1'b0);
            burst_o.cnt    = CNT_W'(2);
          end
          pos_o.col = adv_col;
          pos_o.row = adv_row;
        end
      end
      FUNC_READ: begin
        if (!pending) begin
          // dummy read; the panel's first reply is discarded
          burst_o.res[0] = res_make(KIND_RDATA, half_of(pos_i.col), 8'h00, 1'b0);
          pos_o.phase    = PH_FIRST;
        end
      end
      FUNC_REPLY: begin
        if (pos_i.phase == PH_FIRST) begin
          burst_o.res[0] = page_cmd(pos_i.col, pos_i.row);
          burst_o.res[1] = column_cmd(pos_i.col);
          burst_o.res[2] = res_make(KIND_RDATA, half_of(pos_i.col), 8'h00, 1'b0);
          burst_o.cnt    = CNT_W'(3);
          pos_o.phase    = PH_SECOND;
        end else if (pos_i.phase == PH_SECOND) begin
          if (adv_addr) begin
            burst_o.res[0] = page_cmd(adv_col, adv_row);
            burst_o.res[1] = column_cmd(adv_col);
            burst_o.res[2] = res_make(KIND_DONE, 1'b0, byte_value_i, 1'b0);
            burst_o.cnt    = CNT_W'(3);
          end else begin
            burst_o.res[0] = res_make(KIND_DONE, 1'b0, byte_value_i, 1'b0);
          end
          pos_o.col   = adv_col;
          pos_o.row   = adv_row;
          pos_o.phase = PH_IDLE;
        end
      end
      default: begin
        burst_o.cnt = CNT_W'(1);
      end
    endcase
  end

endmodule

[hdl/dlas_burst.sv]
// Result burst buffer and output register: holds one request's result list and
// hands it out one beat per cycle while rsp_o is ready. Depends on dlas_pkg and dlas_if.
module dlas_burst import dlas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  burst_t      burst_i,
  output logic        free_o,
  dlas_out_if.source  rsp_o
);

  logic             bvld_q, bvld_d;
  burst_t           burst_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_vld_q, out_vld_d;
  res_t             out_q;
  logic             out_last_q;
  logic             pop;
  logic             last_pop;

  assign pop      = bvld_q && (!out_vld_q || rsp_o.ready);
  assign last_pop = pop && (idx_q == IDX_W'(burst_q.cnt - CNT_W'(1)));
  assign free_o   = !bvld_q || last_pop;

  always_comb begin
    bvld_d    = bvld_q;
    idx_d     = idx_q;
    out_vld_d = pop || (out_vld_q && !rsp_o.ready);
    if (load_i) begin
      bvld_d = 1'b1;
      idx_d  = '0;
    end else if (last_pop) begin
      bvld_d = 1'b0;
    end else if (pop) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      bvld_q    <= bvld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
    if (pop) begin
      out_q      <= burst_q.res[idx_q];
      out_last_q <= last_pop;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.kind     = out_q.kind;
  assign rsp_o.half     = out_q.half;
  assign rsp_o.bus_byte = out_q.bus_byte;
  assign rsp_o.error    = out_q.error;
  assign rsp_o.last     = out_last_q;

endmodule

[hdl/dual_half_lcd_address_sequencer.sv]
// Top level of the dual-half graphic LCD address sequencer.
// Depends on dlas_pkg, dlas_if, dlas_decode and dlas_burst.
//
// Takes host requests on req_i (init, set address, write, read, panel read reply)
// and produces panel bus beats and host completions on rsp_o, one result beat per
// cycle while rsp_o is ready, with last marking the final beat of each request.
// A request makes 1 to 5 results and the single burst buffer holds one list, so
// the next request loads once the last beat moves to the output register; a
// one-result request can be taken every cycle while rsp_o is ready. A request
// passes input register, burst buffer and output register. Requests keep
// being taken while results wait on rsp_o, up to one in the input register and
// one in the burst buffer. Column, pixel row and read phase update when the
// request moves from the input register into the burst buffer.
module dual_half_lcd_address_sequencer import dlas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlas_in_if.sink    req_i,
  dlas_out_if.source rsp_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [2:0] func_q;
  logic [7:0] x_col_q;
  logic [7:0] y_row_q;
  logic [7:0] byte_value_q;

  // panel position and read phase
  pos_t   pos_q;
  pos_t   pos_d;
  burst_t burst;
  logic   free;
  logic   load;
  logic   accept;

  assign load        = in_vld_q && free;
  assign req_i.ready = !in_vld_q || load;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      pos_q    <= '{col: '0, row: '0, phase: PH_IDLE};
    end else begin
      in_vld_q <= in_vld_d;
      if (load) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= req_i.func;
      x_col_q      <= req_i.x_col;
      y_row_q      <= req_i.y_row;
      byte_value_q <= req_i.byte_value;
    end
  end

  dlas_decode u_decode (
    .func_i       (func_q),
    .x_col_i      (x_col_q),
    .y_row_i      (y_row_q),
    .byte_value_i (byte_value_q),
    .pos_i        (pos_q),
    .burst_o      (burst),
    .pos_o        (pos_d)
  );

  dlas_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .burst_i (burst),
    .free_o  (free),
    .rsp_o   (rsp_o)
  );

  // Checks

  a_col_in_panel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q.col} < (COL_W + 1)'(PANEL_WIDTH))
    else $error("column outside panel");

  a_burst_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (burst.cnt != '0) && (burst.cnt <= CNT_W'(MAX_RES)))
    else $error("bad burst length");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.last |->
      (rsp_o.kind == KIND_DONE) || (rsp_o.kind == KIND_RDATA))
    else $error("request ends on a bus write");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.kind == KIND_DONE) |-> rsp_o.last)
    else $error("completion not on final beat");

  a_phase_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (pos_q.phase == PH_IDLE) && (pos_d.phase == PH_FIRST) |->
      (burst.cnt == CNT_W'(1)) && (burst.res[0].kind == KIND_RDATA))
    else $error("read started without dummy read");

endmodule
